// ----- hw/rtl/prp_pkg.sv -----
// Shared types, constants and functions for the point rotation block.
// Holds register codes, the quarter-wave sine builder and angle folding helpers.
// No dependencies.
package prp_pkg;

  localparam int TRIG_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int ANGLE_W       = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int QTAB_LAST     = 90;
  localparam int QIDX_W        = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam longint      ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [QIDX_W-1:0] idx;
    logic              neg;
  } quad_sel_t;

  // Multiplies by x twice, going back to 30 fractional bits after each product.
  function automatic logic [63:0] taylor_sq(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] u;
    u = (t * x) >> 30;
    return (u * x) >> 30;
  endfunction

  // Quarter-wave sine entry for whole degree d, rounded to frac fractional bits.
  function automatic logic [63:0] quarter_sine(input int unsigned d, input int unsigned frac);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    x = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
    sum = longint'(x);
    term = taylor_sq(x, x) / 64'd6;
    sum = sum - longint'(term);
    term = taylor_sq(term, x) / 64'd20;
    sum = sum + longint'(term);
    term = taylor_sq(term, x) / 64'd42;
    sum = sum - longint'(term);
    term = taylor_sq(term, x) / 64'd72;
    sum = sum + longint'(term);
    term = taylor_sq(term, x) / 64'd110;
    sum = sum - longint'(term);
    term = taylor_sq(term, x) / 64'd156;
    sum = sum + longint'(term);
    term = taylor_sq(term, x) / 64'd210;
    sum = sum - longint'(term);
    term = taylor_sq(term, x) / 64'd272;
    sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end else if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return 64'((sum + (longint'(1) <<< (29 - frac))) >>> (30 - frac));
  endfunction

  function automatic logic [ANGLE_W-1:0] reduce_angle(input logic [ANGLE_W-1:0] a);
    return (a >= ANGLE_W'(360)) ? a - ANGLE_W'(360) : a;
  endfunction

  // Angle of the cosine: a + 90 degrees, folded back below 360.
  function automatic logic [ANGLE_W-1:0] cos_angle(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W:0] c;
    c = {1'b0, a} + (ANGLE_W + 1)'(90);
    if (c >= (ANGLE_W + 1)'(360)) begin
      c = c - (ANGLE_W + 1)'(360);
    end
    return c[ANGLE_W-1:0];
  endfunction

  function automatic quad_sel_t quad_map(input logic [ANGLE_W-1:0] a);
    quad_sel_t s;
    logic [ANGLE_W-1:0] t;
    if (a <= ANGLE_W'(90)) begin
      t = a;
      s.neg = 1'b0;
    end else if (a <= ANGLE_W'(180)) begin
      t = ANGLE_W'(180) - a;
      s.neg = 1'b0;
    end else if (a <= ANGLE_W'(270)) begin
      t = a - ANGLE_W'(180);
      s.neg = 1'b1;
    end else begin
      t = ANGLE_W'(360) - a;
      s.neg = 1'b1;
    end
    s.idx = t[QIDX_W-1:0];
    return s;
  endfunction

endpackage

// ----- hw/rtl/point_rotate_with_bounds.sv -----
// An accepted point is held in the input register, then rotated and bounded into the
// result register, which holds while out_stall is high. Throughput: one point per cycle
// while in_stall is low; the carried state is the running bounds and run-start flag. A
// configuration write stalls the input while the four-stage matrix pipeline (sine
// lookup, pair products, triple products and sums, rounding) rebuilds the nine terms.
// Reset clears valid state, sets the angles to zero, loads the identity matrix and opens a new run.
module point_rotate_with_bounds #(
  parameter int TRIG_BITS = prp_pkg::TRIG_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [prp_pkg::COORD_W-1:0]     in_x,
  input  logic signed [prp_pkg::COORD_W-1:0]     in_y,
  input  logic signed [prp_pkg::COORD_W-1:0]     in_z,
  input  logic                                   in_last_point,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [prp_pkg::COORD_W-1:0]    out_rot_x,
  output logic signed [prp_pkg::COORD_W-1:0]    out_rot_y,
  output logic signed [prp_pkg::COORD_W-1:0]    out_rot_z,
  output logic signed [prp_pkg::COORD_W-1:0]    out_max_x,
  output logic signed [prp_pkg::COORD_W-1:0]    out_min_x,
  output logic signed [prp_pkg::COORD_W-1:0]    out_max_y,
  output logic signed [prp_pkg::COORD_W-1:0]    out_min_y,
  output logic signed [prp_pkg::COORD_W-1:0]    out_max_z,
  output logic signed [prp_pkg::COORD_W-1:0]    out_min_z,
  output logic                                   out_run_end,
  input  logic                                   cfg_we,
  input  logic [prp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import prp_pkg::*;

  localparam int FRAC = TRIG_BITS - 1;
  localparam int TW   = TRIG_BITS + 1;
  localparam int PW   = 2 * TW;
  localparam int SW   = 3 * TW + 1;
  localparam int AW   = TRIG_BITS + COORD_W + 2;

  localparam logic signed [SW-1:0] T_ONE    = SW'(1) <<< FRAC;
  localparam logic signed [SW-1:0] T_HALF   = SW'(1) <<< (2 * FRAC - 1);
  localparam logic signed [SW-1:0] T_HI     = T_ONE - SW'(1);
  localparam logic signed [SW-1:0] T_LO     = -T_ONE;
  localparam logic signed [TRIG_BITS-1:0] T_DIAG = TRIG_BITS'((1 << FRAC) - 1);
  localparam logic signed [AW-1:0] P_HALF   = AW'(1) <<< (FRAC - 1);
  localparam logic signed [AW-1:0] SAT_HI   = AW'(32'sh7FFFFFFF);
  localparam logic signed [AW-1:0] SAT_LO   = AW'(32'sh80000000);

  logic [TRIG_BITS-1:0] qsin [0:QTAB_LAST];

  for (genvar d = 0; d <= QTAB_LAST; d++) begin : g_qsin
    assign qsin[d] = TRIG_BITS'(quarter_sine(d, FRAC));
  end

  // Configuration and matrix pipeline.
  logic [ANGLE_W-1:0]          angle_r [0:2];
  logic [3:0]                  pipe_v_r;
  logic signed [TW-1:0]        sin_c [0:2];
  logic signed [TW-1:0]        cos_c [0:2];
  logic signed [TW-1:0]        sin_r [0:2];
  logic signed [TW-1:0]        cos_r [0:2];
  logic signed [PW-1:0]        p_cycz_r, p_sxsy_r, p_cxsz_r, p_sxsz_r, p_cxsy_r;
  logic signed [PW-1:0]        p_cysz_r, p_cxcz_r, p_sxcz_r, p_sxcy_r, p_cxcy_r;
  logic signed [TW-1:0]        sy2_r, sz2_r, cz2_r;
  logic signed [SW-1:0]        t_czsxsy, t_szsxsy, t_czcxsy, t_szcxsy;
  logic signed [SW-1:0]        sum_nxt [0:8];
  logic signed [SW-1:0]        sum_r [0:8];
  logic signed [TRIG_BITS-1:0] term_nxt [0:8];
  logic signed [TRIG_BITS-1:0] matrix_r [0:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        angle_r[a] <= '0;
      end
      pipe_v_r <= '0;
    end else begin
      pipe_v_r <= {pipe_v_r[2:0], cfg_we};
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ANGLE_X: angle_r[0] <= cfg_data;
          REG_ANGLE_Y: angle_r[1] <= cfg_data;
          REG_ANGLE_Z: angle_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_trig
    quad_sel_t          s_sel, c_sel;
    logic [ANGLE_W-1:0] red;
    logic signed [TW-1:0] s_mag, c_mag;
    assign red   = reduce_angle(angle_r[a]);
    assign s_sel = quad_map(red);
    assign c_sel = quad_map(cos_angle(red));
    assign s_mag = $signed({1'b0, qsin[s_sel.idx]});
    assign c_mag = $signed({1'b0, qsin[c_sel.idx]});
    assign sin_c[a] = s_sel.neg ? -s_mag : s_mag;
    assign cos_c[a] = c_sel.neg ? -c_mag : c_mag;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sin_r[a] <= sin_c[a];
      cos_r[a] <= cos_c[a];
    end
    p_cycz_r <= cos_r[1] * cos_r[2];
    p_sxsy_r <= sin_r[0] * sin_r[1];
    p_cxsz_r <= cos_r[0] * sin_r[2];
    p_sxsz_r <= sin_r[0] * sin_r[2];
    p_cxsy_r <= cos_r[0] * sin_r[1];
    p_cysz_r <= cos_r[1] * sin_r[2];
    p_cxcz_r <= cos_r[0] * cos_r[2];
    p_sxcz_r <= sin_r[0] * cos_r[2];
    p_sxcy_r <= sin_r[0] * cos_r[1];
    p_cxcy_r <= cos_r[0] * cos_r[1];
    sy2_r    <= sin_r[1];
    sz2_r    <= sin_r[2];
    cz2_r    <= cos_r[2];
  end

  function automatic logic signed [SW-1:0] up_f(input logic signed [PW-1:0] v);
    return SW'(v) <<< FRAC;
  endfunction

  assign t_czsxsy = cz2_r * p_sxsy_r;
  assign t_szsxsy = sz2_r * p_sxsy_r;
  assign t_czcxsy = cz2_r * p_cxsy_r;
  assign t_szcxsy = sz2_r * p_cxsy_r;

  assign sum_nxt[0] = up_f(p_cycz_r);
  assign sum_nxt[1] = t_czsxsy - up_f(p_cxsz_r);
  assign sum_nxt[2] = up_f(p_sxsz_r) + t_czcxsy;
  assign sum_nxt[3] = up_f(p_cysz_r);
  assign sum_nxt[4] = up_f(p_cxcz_r) + t_szsxsy;
  assign sum_nxt[5] = t_szcxsy - up_f(p_sxcz_r);
  assign sum_nxt[6] = -(SW'(sy2_r) <<< (2 * FRAC));
  assign sum_nxt[7] = up_f(p_sxcy_r);
  assign sum_nxt[8] = up_f(p_cxcy_r);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      sum_r[k] <= sum_nxt[k];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_term
    logic signed [SW-1:0] rnd;
    assign rnd = (sum_r[k] + T_HALF) >>> (2 * FRAC);
    assign term_nxt[k] = (rnd > T_HI) ? TRIG_BITS'(T_HI) :
                         (rnd < T_LO) ? TRIG_BITS'(T_LO) : TRIG_BITS'(rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        matrix_r[k] <= (k == 0 || k == 4 || k == 8) ? T_DIAG : '0;
      end
    end else if (pipe_v_r[3]) begin
      for (int k = 0; k < 9; k++) begin
        matrix_r[k] <= term_nxt[k];
      end
    end
  end

  // Point path: input register, rotation and bounds, result register.
  logic                        s1_v_r;
  logic signed [COORD_W-1:0]   coord_r [0:2];
  logic                        last_r;
  logic                        out_valid_r;
  logic                        run_start_r;
  logic                        out_free;
  logic                        s1_go;
  logic                        in_acc;
  logic signed [COORD_W-1:0]   rot_c [0:2];
  logic signed [COORD_W-1:0]   max_nxt [0:2];
  logic signed [COORD_W-1:0]   min_nxt [0:2];
  logic signed [COORD_W-1:0]   rot_r [0:2];
  logic signed [COORD_W-1:0]   max_r [0:2];
  logic signed [COORD_W-1:0]   min_r [0:2];
  logic                        run_end_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_v_r && out_free;
  assign in_stall = cfg_we || (|pipe_v_r) || (s1_v_r && !out_free);
  assign in_acc   = in_valid && !in_stall;

  for (genvar i = 0; i < 3; i++) begin : g_row
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] rnd;
    assign acc = matrix_r[3 * i] * coord_r[0] + matrix_r[3 * i + 1] * coord_r[1]
               + matrix_r[3 * i + 2] * coord_r[2];
    assign rnd = (acc + P_HALF) >>> FRAC;
    assign rot_c[i] = (rnd > SAT_HI) ? COORD_W'(SAT_HI) :
                      (rnd < SAT_LO) ? COORD_W'(SAT_LO) : COORD_W'(rnd);
    assign max_nxt[i] = (run_start_r || rot_c[i] > max_r[i]) ? rot_c[i] : max_r[i];
    assign min_nxt[i] = (run_start_r || rot_c[i] < min_r[i]) ? rot_c[i] : min_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      run_start_r <= 1'b1;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      out_valid_r <= s1_go || (out_valid_r && out_stall);
      if (s1_go) begin
        run_start_r <= last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      coord_r[0] <= in_x;
      coord_r[1] <= in_y;
      coord_r[2] <= in_z;
      last_r     <= in_last_point;
    end
    if (s1_go) begin
      for (int i = 0; i < 3; i++) begin
        rot_r[i] <= rot_c[i];
        max_r[i] <= max_nxt[i];
        min_r[i] <= min_nxt[i];
      end
      run_end_r <= last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_rot_x   = rot_r[0];
  assign out_rot_y   = rot_r[1];
  assign out_rot_z   = rot_r[2];
  assign out_max_x   = max_r[0];
  assign out_min_x   = min_r[0];
  assign out_max_y   = max_r[1];
  assign out_min_y   = min_r[1];
  assign out_max_z   = max_r[2];
  assign out_min_z   = min_r[2];
  assign out_run_end = run_end_r;

endmodule
